// ===== hw/rtl/sorted_keyed_record_table_assert.svh =====
// Assertion macros shared by the sorted key table RTL.
// Each macro takes a label, a clock, an active-low reset, a condition and a check.
`ifndef SORTED_KEYED_RECORD_TABLE_ASSERT_SVH
`define SORTED_KEYED_RECORD_TABLE_ASSERT_SVH

// The check must hold in the same cycle as the condition.
`define SKRT_ASSERT_IMP(lbl, clk, rst_n, cond, chk) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error("sorted key table check failed");

// The check must hold in the cycle after the condition.
`define SKRT_ASSERT_NXT(lbl, clk, rst_n, cond, chk) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error("sorted key table check failed");

`endif

// ===== hw/rtl/sktab_pkg.sv =====
// Package for the sorted key table: word types, operation and status codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sktab_pkg;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_HANDLE_BITS = 16;

    // Number of cells whose results are merged in one registered group.
    localparam int GATHER_GROUP = 16;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_FIND   = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_GETH   = 3'd3;
    localparam logic [2:0] MODE_GETC   = 3'd4;
    localparam logic [2:0] MODE_SETC   = 3'd5;
    localparam logic [2:0] MODE_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANK      = 2'd3;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] key;
        logic [15:0]        record_handle;
        logic [7:0]         rank;
        logic [31:0]        client_word;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [31:0] found_client;
        logic [8:0]  entry_count;
    } rsp_word_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp;        // latch compare flags against the incoming word
        logic ins;        // open a slot at the insert point and shift right
        logic rem;        // close the slot of the hit and shift left
        logic rep;        // replace the handle of the hit
        logic setc;       // write the client word of the ranked entry
        logic pick_rank;  // handle output follows the rank match, not the key hit
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RED  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

// ===== hw/rtl/sorted_keyed_record_table.sv =====
// Sorted key table: a key-ordered chain of entry cells with a small sequencer.
// Depends on sktab_pkg, sktab_cell, sktab_gather and the assertion header.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on req (req_valid, req_stall); each word carries one operation:
// add, find, remove, get handle or client by rank, set client by rank, or clear.
// Every request yields exactly one response word on rsp (rsp_valid, rsp_stall)
// with a status, the handle or client read, and the entry count afterwards.
// A request is taken only while the sequencer is idle. At the accepting edge all
// cells compare their key and index against it; in the next cycle the chain
// shifts or writes in one step and the merge groups register the read data;
// then the response register is loaded as soon as it is free. The next request
// can be taken at the edge that ends the first cycle of a valid response, so a
// new request is never taken while the last one is still in progress.
// If the receiver stalls, the response register holds its word; a new request
// is still accepted and processed, and it waits in its last cycle until the
// response register frees up.
// Reset empties the table (the count returns to zero) and drops any response.
// Entry storage is not cleared; entries beyond the count are never read.

module sorted_keyed_record_table #(
    parameter int CAPACITY    = sktab_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = sktab_pkg::DEF_HANDLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  sktab_pkg::req_word_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sktab_pkg::rsp_word_t rsp
);

    localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int CW = $clog2(CAPACITY + 1);

    sktab_pkg::state_t    state_reg, state_next;
    sktab_pkg::req_word_t op_reg;
    sktab_pkg::rsp_word_t rsp_reg;
    sktab_pkg::cell_ctrl_t ctrl;
    logic                 rsp_valid_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [1:0]           status_reg, status_next;

    logic signed [31:0]   keys    [CAPACITY];
    logic [HW-1:0]        handles [CAPACITY];
    logic [31:0]          clients [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;
    logic [CAPACITY-1:0][HW-1:0] pick_h;
    logic [CAPACITY-1:0][31:0]   pick_c;
    logic [HW-1:0]        gath_h;
    logic [31:0]          gath_c;

    logic                 accept;
    logic                 hit;
    logic                 full;
    logic                 rank_ok;
    logic                 in_red;
    logic                 in_fin;
    logic                 rsp_free;
    logic [31:0]          cnt_ext;
    logic [15:0]          fh;
    logic [31:0]          fc;

    assign req_stall = (state_reg != sktab_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_red    = (state_reg == sktab_pkg::S_RED);
    assign in_fin    = (state_reg == sktab_pkg::S_FIN);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign hit     = |eq_vec;
    assign full    = (count_reg == CW'(CAPACITY));
    assign rank_ok = (32'(op_reg.rank) < 32'(count_reg));

    always_comb
    begin
        ctrl.cmp       = accept;
        ctrl.ins       = in_red && (op_reg.mode == sktab_pkg::MODE_ADD) && !hit && !full;
        ctrl.rem       = in_red && (op_reg.mode == sktab_pkg::MODE_REMOVE) && hit;
        ctrl.rep       = in_red && (op_reg.mode == sktab_pkg::MODE_ADD) && hit;
        ctrl.setc      = in_red && (op_reg.mode == sktab_pkg::MODE_SETC) && rank_ok;
        ctrl.pick_rank = (op_reg.mode == sktab_pkg::MODE_GETH);
    end

    always_comb
    begin
        status_next = sktab_pkg::ST_OK;
        count_next  = count_reg;
        case (op_reg.mode)
            sktab_pkg::MODE_ADD:
            begin
                if (!hit && full)
                begin
                    status_next = sktab_pkg::ST_FULL;
                end
                else if (!hit)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            sktab_pkg::MODE_FIND:
            begin
                if (!hit)
                begin
                    status_next = sktab_pkg::ST_NOT_FOUND;
                end
            end
            sktab_pkg::MODE_REMOVE:
            begin
                if (!hit)
                begin
                    status_next = sktab_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            sktab_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                if (op_reg.mode inside {sktab_pkg::MODE_GETH, sktab_pkg::MODE_GETC,
                                        sktab_pkg::MODE_SETC})
                begin
                    if (!rank_ok)
                    begin
                        status_next = sktab_pkg::ST_RANK;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sktab_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sktab_pkg::S_RED;
                end
            end
            sktab_pkg::S_RED:
            begin
                state_next = sktab_pkg::S_FIN;
            end
            sktab_pkg::S_FIN:
            begin
                if (rsp_free)
                begin
                    state_next = sktab_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sktab_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sktab_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_red)
            begin
                count_reg <= count_next;
            end
            if (in_fin && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        fh = '0;
        fc = '0;
        if ((op_reg.mode == sktab_pkg::MODE_FIND) || (op_reg.mode == sktab_pkg::MODE_GETH))
        begin
            fh = 16'(gath_h);
        end
        if (op_reg.mode == sktab_pkg::MODE_GETC)
        begin
            fc = gath_c;
        end
    end

    assign cnt_ext = 32'(count_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req;
        end
        if (in_red)
        begin
            status_reg <= status_next;
        end
        if (in_fin && rsp_free)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.found_handle <= fh;
            rsp_reg.found_client <= fc;
            rsp_reg.entry_count  <= cnt_ext[8:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int LI = (i == 0) ? 0 : i - 1;
        localparam int RI = (i == CAPACITY - 1) ? i : i + 1;

        sktab_cell #(
            .IDX (i),
            .HW  (HW),
            .CW  (CW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .cmp_key      (req.key),
            .cmp_rank     (req.rank),
            .count        (count_reg),
            .wr_key       (op_reg.key),
            .wr_handle    (op_reg.record_handle[HW-1:0]),
            .wr_client    (op_reg.client_word),
            .left_lt      ((i == 0) ? 1'b1 : lt_vec[LI]),
            .left_key     (keys[LI]),
            .left_handle  (handles[LI]),
            .left_client  (clients[LI]),
            .right_key    (keys[RI]),
            .right_handle (handles[RI]),
            .right_client (clients[RI]),
            .key          (keys[i]),
            .handle       (handles[i]),
            .client       (clients[i]),
            .lt           (lt_vec[i]),
            .eq           (eq_vec[i]),
            .pick_handle  (pick_h[i]),
            .pick_client  (pick_c[i])
        );
    end

    sktab_gather #(
        .N (CAPACITY),
        .W (HW)
    ) u_gather_h (
        .clk    (clk),
        .words  (pick_h),
        .result (gath_h)
    );

    sktab_gather #(
        .N (CAPACITY),
        .W (32)
    ) u_gather_c (
        .clk    (clk),
        .words  (pick_c),
        .result (gath_c)
    );

`include "sorted_keyed_record_table_assert.svh"

    // Keys are unique, so at most one cell can report a hit.
    `SKRT_ASSERT_IMP(a_one_hit, clk, rst_n, 1'b1, $onehot0(eq_vec))
    // The count never runs past the number of cells.
    `SKRT_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, 32'(count_reg) <= 32'(CAPACITY))
    // The count changes only at the end of the write cycle.
    `SKRT_ASSERT_NXT(a_cnt_step, clk, rst_n, !in_red, count_reg == $past(count_reg))
    // A new response appears only after the final sequencer cycle.
    `SKRT_ASSERT_NXT(a_rsp_src, clk, rst_n, !in_fin && !rsp_valid_reg, !rsp_valid_reg)

endmodule

// ===== hw/rtl/sktab_cell.sv =====
// One cell of the ordered chain: holds one entry and its compare flags.
// Depends on sktab_pkg; instantiated in a row by sorted_keyed_record_table.
`timescale 1ns / 1ps

module sktab_cell #(
    parameter int IDX = 0,
    parameter int HW  = 16,
    parameter int CW  = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sktab_pkg::cell_ctrl_t  ctrl,
    input  logic signed [31:0]     cmp_key,
    input  logic [7:0]             cmp_rank,
    input  logic [CW-1:0]          count,
    input  logic signed [31:0]     wr_key,
    input  logic [HW-1:0]          wr_handle,
    input  logic [31:0]            wr_client,
    input  logic                   left_lt,
    input  logic signed [31:0]     left_key,
    input  logic [HW-1:0]          left_handle,
    input  logic [31:0]            left_client,
    input  logic signed [31:0]     right_key,
    input  logic [HW-1:0]          right_handle,
    input  logic [31:0]            right_client,
    output logic signed [31:0]     key,
    output logic [HW-1:0]          handle,
    output logic [31:0]            client,
    output logic                   lt,
    output logic                   eq,
    output logic [HW-1:0]          pick_handle,
    output logic [31:0]            pick_client
);

    localparam logic [31:0] IDX_W = 32'(IDX);

    logic signed [31:0] key_reg;
    logic [HW-1:0]      handle_reg;
    logic [31:0]        client_reg;
    logic               lt_reg;
    logic               eq_reg;
    logic               rk_reg;
    logic               occ;
    logic               hsel;

    assign occ = (32'(count) > IDX_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
            rk_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            lt_reg <= occ && (key_reg < cmp_key);
            eq_reg <= occ && (key_reg == cmp_key);
            rk_reg <= occ && (32'(cmp_rank) == IDX_W);
        end
    end

    // Entries below the insert point (lt set) never move. The cell at the
    // insert point takes the new entry, the ones above take their left neighbor.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            if (!lt_reg)
            begin
                if (left_lt)
                begin
                    key_reg    <= wr_key;
                    handle_reg <= wr_handle;
                    client_reg <= '0;
                end
                else
                begin
                    key_reg    <= left_key;
                    handle_reg <= left_handle;
                    client_reg <= left_client;
                end
            end
        end
        else if (ctrl.rem)
        begin
            if (!lt_reg)
            begin
                key_reg    <= right_key;
                handle_reg <= right_handle;
                client_reg <= right_client;
            end
        end
        else if (ctrl.rep)
        begin
            if (eq_reg)
            begin
                handle_reg <= wr_handle;
            end
        end
        else if (ctrl.setc)
        begin
            if (rk_reg)
            begin
                client_reg <= wr_client;
            end
        end
    end

    assign hsel        = ctrl.pick_rank ? rk_reg : eq_reg;
    assign pick_handle = hsel ? handle_reg : '0;
    assign pick_client = rk_reg ? client_reg : '0;

    assign key    = key_reg;
    assign handle = handle_reg;
    assign client = client_reg;
    assign lt     = lt_reg;
    assign eq     = eq_reg;

endmodule

// ===== hw/rtl/sktab_gather.sv =====
// Two-level OR merge of the masked cell outputs: registered groups, then a final OR.
// Depends on sktab_pkg for the group size.
`timescale 1ns / 1ps

module sktab_gather #(
    parameter int N = 256,
    parameter int W = 16
) (
    input  logic                clk,
    input  logic [N-1:0][W-1:0] words,
    output logic [W-1:0]        result
);

    localparam int G  = sktab_pkg::GATHER_GROUP;
    localparam int NG = (N + G - 1) / G;

    logic [NG-1:0][W-1:0] grp_reg;
    logic [NG-1:0][W-1:0] grp_next;

    // At most one cell drives a nonzero word, so OR acts as a select.
    always_comb
    begin
        grp_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            for (int j = 0; j < G; j++)
            begin
                if (g * G + j < N)
                begin
                    grp_next[g] = grp_next[g] | words[g * G + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NG; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule

// ===== tb/sv/sorted_keyed_record_table_tb.sv =====
// Testbench for the sorted key table: directed rows, then random operation mixes
// and fill-to-full passes, checked word by word against the rows or a shadow table.
// Depends on sktab_pkg and sorted_keyed_record_table.
`timescale 1ns / 1ps

module sorted_keyed_record_table_tb;
    import sktab_pkg::*;

    localparam int         TABLE_SIZE  = DEF_CAPACITY;
    localparam logic [15:0] HANDLE_MASK = 16'((64'd1 << DEF_HANDLE_BITS) - 1);
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int         ITEMS_TOTAL = 1300;
    localparam int         CYCLE_LIMIT = 300000;

    typedef struct {
        logic signed [31:0] key;
        logic [15:0]        handle;
        logic [31:0]        client;
    } tbl_entry_t;

    typedef struct {
        req_word_t w;
        bit        typed;
        rsp_word_t want;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    tbl_entry_t shadow_tbl[$];
    rsp_word_t  predicted_rsp_q[$];
    dir_row_t   dir_rows[$];
    int         err_count = 0;
    int         cycle_count = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;

    sorted_keyed_record_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Applies one operation to the shadow table and returns the response word.
    function automatic rsp_word_t table_apply(input req_word_t w);
        rsp_word_t  r;
        tbl_entry_t e;
        int         pos;
        bit         hit;
        bit         rank_ok;
        r = '0;
        r.status = ST_OK;
        pos = 0;
        while (pos < shadow_tbl.size() && shadow_tbl[pos].key < w.key)
            pos++;
        hit = pos < shadow_tbl.size() && shadow_tbl[pos].key == w.key;
        rank_ok = int'(w.rank) < shadow_tbl.size();
        case (w.mode)
            MODE_ADD:
            begin
                if (hit)
                begin
                    e = shadow_tbl[pos];
                    e.handle = w.record_handle & HANDLE_MASK;
                    shadow_tbl[pos] = e;
                end
                else if (shadow_tbl.size() >= TABLE_SIZE)
                    r.status = ST_FULL;
                else
                begin
                    e.key = w.key;
                    e.handle = w.record_handle & HANDLE_MASK;
                    e.client = '0;
                    shadow_tbl.insert(pos, e);
                end
            end
            MODE_FIND:
            begin
                if (hit)
                    r.found_handle = shadow_tbl[pos].handle;
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_REMOVE:
            begin
                if (hit)
                    shadow_tbl.delete(pos);
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_GETH:
            begin
                if (rank_ok)
                    r.found_handle = shadow_tbl[w.rank].handle;
                else
                    r.status = ST_RANK;
            end
            MODE_GETC:
            begin
                if (rank_ok)
                    r.found_client = shadow_tbl[w.rank].client;
                else
                    r.status = ST_RANK;
            end
            MODE_SETC:
            begin
                if (rank_ok)
                begin
                    e = shadow_tbl[w.rank];
                    e.client = w.client_word;
                    shadow_tbl[w.rank] = e;
                end
                else
                    r.status = ST_RANK;
            end
            MODE_CLEAR:
                shadow_tbl.delete();
            default:
                ;
        endcase
        r.entry_count = 9'(shadow_tbl.size());
        return r;
    endfunction

    function automatic void flag_mismatch(input string fld, input logic [31:0] want,
                                          input logic [31:0] got);
        $display("%0t: %s expected %0h got %0h", $time, fld, want, got);
        err_count++;
    endfunction

    task automatic check_rsp(input rsp_word_t got);
        rsp_word_t want;
        if (predicted_rsp_q.size() == 0)
        begin
            $display("%0t: response word expected none got %h", $time, got);
            err_count++;
        end
        else
        begin
            want = predicted_rsp_q.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", want.status, got.status);
            if (got.found_handle !== want.found_handle)
                flag_mismatch("found_handle", want.found_handle, got.found_handle);
            if (got.found_client !== want.found_client)
                flag_mismatch("found_client", want.found_client, got.found_client);
            if (got.entry_count !== want.entry_count)
                flag_mismatch("entry_count", want.entry_count, got.entry_count);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_rsp(rsp);
    end

    // The receiver switches between no stalls, scattered stalls and long stall runs.
    always @(negedge clk)
    begin
        int  rx_mode;
        int  run_left;
        logic nxt;
        if (cycle_count % 256 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            1: nxt = ($urandom_range(0, 99) < 35);
            2:
            begin
                nxt = rsp_stall;
                if (run_left <= 0)
                begin
                    nxt = ~rsp_stall;
                    run_left = $urandom_range(1, 10);
                end
                run_left--;
            end
            default: nxt = 1'b0;
        endcase
        rsp_stall <= nxt;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t r;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        r = table_apply(w);
        predicted_rsp_q.insert(predicted_rsp_q.size(), typed ? want : r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input req_word_t w);
        send_word(w, 1'b0, '0);
    endtask

    task automatic drain;
        req_valid <= 1'b0;
        do @(negedge clk); while (predicted_rsp_q.size() != 0);
    endtask

    function automatic void row(input logic [2:0] m, input logic [31:0] k,
                                input logic [15:0] h, input logic [7:0] rk,
                                input logic [31:0] cw, input bit typed,
                                input logic [1:0] st, input logic [15:0] fh,
                                input logic [31:0] fc, input logic [8:0] cnt);
        dir_row_t d;
        d.w.mode = m;
        d.w.key = k;
        d.w.record_handle = h;
        d.w.rank = rk;
        d.w.client_word = cw;
        d.typed = typed;
        d.want.status = st;
        d.want.found_handle = fh;
        d.want.found_client = fc;
        d.want.entry_count = cnt;
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (shadow_tbl.size() > 0 && $urandom_range(0, 99) < 60)
            return shadow_tbl[$urandom_range(0, shadow_tbl.size() - 1)].key;
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 32)) - 16;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        int p;
        p = $urandom_range(0, 99);
        if (p < 26) return MODE_ADD;
        if (p < 46) return MODE_FIND;
        if (p < 60) return MODE_REMOVE;
        if (p < 70) return MODE_GETH;
        if (p < 80) return MODE_GETC;
        if (p < 95) return MODE_SETC;
        if (p < 97) return MODE_CLEAR;
        return MODE_UNUSED;
    endfunction

    function automatic req_word_t rand_word(input logic [2:0] m);
        req_word_t w;
        w.mode = m;
        w.key = pick_key();
        w.record_handle = 16'($urandom);
        if (shadow_tbl.size() > 0 && $urandom_range(0, 99) < 80)
            w.rank = 8'($urandom_range(0, shadow_tbl.size() - 1));
        else
            w.rank = 8'($urandom_range(0, 255));
        w.client_word = $urandom;
        return w;
    endfunction

    initial
    begin
        req_word_t w;
        int        phase_no;

        // Table after the adds: min, -1, 0, max.
        row(MODE_FIND,   32'h0,        16'h0,    8'd0,   32'h0,        1, ST_NOT_FOUND, 0, 0, 0);
        row(MODE_GETH,   32'h0,        16'h0,    8'd0,   32'h0,        1, ST_RANK, 0, 0, 0);
        row(MODE_SETC,   32'hffffffff, 16'hffff, 8'd0,   32'hffffffff, 1, ST_RANK, 0, 0, 0);
        row(MODE_REMOVE, 32'h5,        16'h0,    8'd0,   32'h0,        1, ST_NOT_FOUND, 0, 0, 0);
        row(MODE_ADD,    32'h80000000, 16'hffff, 8'hff,  32'hffffffff, 1, ST_OK, 0, 0, 1);
        row(MODE_ADD,    32'h7fffffff, 16'h0000, 8'd0,   32'h0,        1, ST_OK, 0, 0, 2);
        row(MODE_ADD,    32'h0,        16'ha5a5, 8'd3,   32'h0,        1, ST_OK, 0, 0, 3);
        row(MODE_ADD,    32'hffffffff, 16'h5a5a, 8'd0,   32'h0,        1, ST_OK, 0, 0, 4);
        row(MODE_FIND,   32'h80000000, 16'h0,    8'd0,   32'h0,        1, ST_OK, 16'hffff, 0, 4);
        row(MODE_FIND,   32'h7fffffff, 16'hffff, 8'd0,   32'h0,        1, ST_OK, 0, 0, 4);
        row(MODE_GETH,   32'h0,        16'h0,    8'd1,   32'h0,        0, ST_OK, 0, 0, 0);
        row(MODE_GETC,   32'h0,        16'h0,    8'd3,   32'h0,        1, ST_OK, 0, 0, 4);
        row(MODE_SETC,   32'h0,        16'h0,    8'd3,   32'hffffffff, 1, ST_OK, 0, 0, 4);
        row(MODE_GETC,   32'h0,        16'h0,    8'd3,   32'h0,        0, ST_OK, 0, 0, 0);
        row(MODE_SETC,   32'h0,        16'h0,    8'd0,   32'h12345678, 0, ST_OK, 0, 0, 0);
        row(MODE_ADD,    32'h0,        16'h1111, 8'd0,   32'h0,        1, ST_OK, 0, 0, 4);
        row(MODE_FIND,   32'h0,        16'h0,    8'd0,   32'h0,        0, ST_OK, 0, 0, 0);
        row(MODE_GETC,   32'h0,        16'h0,    8'd2,   32'h0,        0, ST_OK, 0, 0, 0);
        row(MODE_GETH,   32'h0,        16'h0,    8'd4,   32'h0,        1, ST_RANK, 0, 0, 4);
        row(MODE_GETC,   32'h0,        16'h0,    8'd255, 32'h0,        1, ST_RANK, 0, 0, 4);
        row(MODE_REMOVE, 32'h1,        16'h0,    8'd0,   32'h0,        1, ST_NOT_FOUND, 0, 0, 4);
        row(MODE_REMOVE, 32'h80000000, 16'h0,    8'd0,   32'h0,        1, ST_OK, 0, 0, 3);
        row(MODE_UNUSED, 32'hffffffff, 16'hffff, 8'hff,  32'hffffffff, 1, ST_OK, 0, 0, 3);
        row(MODE_CLEAR,  32'h0,        16'h0,    8'd0,   32'h0,        1, ST_OK, 0, 0, 0);
        row(MODE_FIND,   32'h7fffffff, 16'h0,    8'd0,   32'h0,        1, ST_NOT_FOUND, 0, 0, 0);

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        drain;

        phase_no = 0;
        while (items_sent < ITEMS_TOTAL)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 2 || phase_no == 6)
            begin
                // Fill to capacity, then probe the full table and thin it out again.
                drain;
                while (shadow_tbl.size() < TABLE_SIZE)
                begin
                    w = rand_word(MODE_ADD);
                    w.key = $urandom;
                    send_random(w);
                end
                repeat (24)
                begin
                    w = rand_word(pick_mode());
                    if (w.mode == MODE_ADD && $urandom_range(0, 1))
                        w.key = $urandom;
                    if (w.mode == MODE_CLEAR)
                        w.mode = MODE_FIND;
                    send_random(w);
                end
                repeat (60)
                    send_random(rand_word(MODE_REMOVE));
            end
            else
            begin
                repeat ($urandom_range(40, 120))
                    send_random(rand_word(pick_mode()));
            end
            phase_no++;
        end
        req_valid <= 1'b0;

        while (predicted_rsp_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sktab_pkg.sv
hw/rtl/sktab_cell.sv
hw/rtl/sktab_gather.sv
hw/rtl/sorted_keyed_record_table.sv
tb/sv/sorted_keyed_record_table_tb.sv
